// ----- src/necd_pkg.sv -----
// Package for the NEC infrared frame decoder.
// Holds the command codes, timing windows, code width and request/result types.
// No dependencies; the decoder modules import it, while the two interfaces do not.
`timescale 1ns / 1ps
`default_nettype none

package necd_pkg;

    // Number of data bits in one frame.
    localparam int CODE_BITS = 32;
    // Width of the received-bit counter (counts 0 .. CODE_BITS-1).
    localparam int CNT_W     = $clog2(CODE_BITS);
    localparam int TIME_W    = 16;

    // Command codes carried by a request.
    localparam logic [1:0] CMD_EDGE    = 2'd0;
    localparam logic [1:0] CMD_TIMEOUT = 2'd1;
    localparam logic [1:0] CMD_REARM   = 2'd2;

    // Timing windows in microseconds.
    localparam logic [TIME_W-1:0] LEAD_MARK_LO  = 16'd8500;
    localparam logic [TIME_W-1:0] LEAD_MARK_HI  = 16'd9500;
    localparam logic [TIME_W-1:0] LEAD_SPACE_LO = 16'd4000;
    localparam logic [TIME_W-1:0] LEAD_SPACE_HI = 16'd5000;
    localparam logic [TIME_W-1:0] BIT_MARK_LO   = 16'd400;
    localparam logic [TIME_W-1:0] BIT_MARK_HI   = 16'd700;
    localparam logic [TIME_W-1:0] BIT_SPACE_LO  = 16'd400;
    localparam logic [TIME_W-1:0] BIT_SPACE_HI  = 16'd1800;
    localparam logic [TIME_W-1:0] BIT_ONE_MIN   = 16'd1000;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [TIME_W-1:0] elapsed_us;
    } t_req;

    typedef struct packed {
        logic        code_valid;
        logic [31:0] frame_code;
        logic [7:0]  button;
        logic        frame_error;
    } t_result;

endpackage : necd_pkg

`default_nettype wire

// ----- src/necd_req_if.sv -----
// Request channel of the NEC infrared frame decoder: valid, ready and edge payload.
// Depends on nothing; widths match the types in necd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface necd_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [15:0] elapsed_us;

    modport source (output valid, output cmd, output elapsed_us, input ready);
    modport sink   (input valid, input cmd, input elapsed_us, output ready);
endinterface : necd_req_if

`default_nettype wire

// ----- src/necd_res_if.sv -----
// Result channel of the NEC infrared frame decoder: valid, ready and decode result.
// Depends on nothing; widths match the types in necd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface necd_res_if;
    logic        valid;
    logic        ready;
    logic        code_valid;
    logic [31:0] frame_code;
    logic [7:0]  button;
    logic        frame_error;

    modport source (output valid, output code_valid, output frame_code, output button,
                    output frame_error, input ready);
    modport sink   (input valid, input code_valid, input frame_code, input button,
                    input frame_error, output ready);
endinterface : necd_res_if

`default_nettype wire

// ----- src/necd_in_reg.sv -----
// Input register stage of the NEC decoder: captures one request per cycle while empty or moving on.
// Depends on necd_pkg and necd_req_if.
`timescale 1ns / 1ps
`default_nettype none

module necd_in_reg (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    necd_req_if.sink           i_req,
    input  wire logic          i_advance,
    output logic               o_valid,
    output necd_pkg::t_req     o_item
);
    import necd_pkg::*;

    logic r_valid;
    t_req r_item;

    // The stage takes a new request when empty or when its content moves on.
    assign i_req.ready = !r_valid || i_advance;

    // Valid flag of the stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_valid <= i_req.valid;
        end
    end

    // Payload capture.
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_item.cmd        <= i_req.cmd;
            r_item.elapsed_us <= i_req.elapsed_us;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule : necd_in_reg

`default_nettype wire

// ----- src/necd_fsm.sv -----
// Frame state machine of the NEC decoder: checks each duration and shifts in bits.
// Depends on necd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module necd_fsm (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_advance,
    input  wire necd_pkg::t_req i_item,
    output necd_pkg::t_result  o_res
);
    import necd_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE       = 3'd0,
        PH_LEAD_MARK  = 3'd1,
        PH_LEAD_SPACE = 3'd2,
        PH_BIT_MARK   = 3'd3,
        PH_BIT_SPACE  = 3'd4
    } t_phase;

    t_phase               r_phase, n_phase;
    logic [CNT_W-1:0]     r_bits, n_bits;
    logic [CODE_BITS-1:0] r_shift, n_shift;
    logic                 r_locked, n_locked;

    logic [TIME_W-1:0]    t;
    logic [CODE_BITS-1:0] shifted;
    logic [63:0]          code_ext;
    t_result              res;

    assign t        = i_item.elapsed_us;
    assign shifted  = {r_shift[CODE_BITS-2:0], (t >= BIT_ONE_MIN)};
    assign code_ext = 64'(shifted);

    // Next state and result for the request in the input register.
    always_comb begin
        n_phase  = r_phase;
        n_bits   = r_bits;
        n_shift  = r_shift;
        n_locked = r_locked;
        res      = '0;
        case (i_item.cmd)
            CMD_EDGE: begin
                if (!r_locked) begin
                    case (r_phase)
                        PH_LEAD_MARK: begin
                            if (t > LEAD_MARK_LO && t < LEAD_MARK_HI) begin
                                n_phase = PH_LEAD_SPACE;
                            end else begin
                                n_phase         = PH_IDLE;
                                res.frame_error = 1'b1;
                            end
                        end
                        PH_LEAD_SPACE: begin
                            if (t > LEAD_SPACE_LO && t < LEAD_SPACE_HI) begin
                                n_phase = PH_BIT_MARK;
                            end else begin
                                n_phase         = PH_IDLE;
                                res.frame_error = 1'b1;
                            end
                        end
                        PH_BIT_MARK: begin
                            if (t > BIT_MARK_LO && t < BIT_MARK_HI) begin
                                n_phase = PH_BIT_SPACE;
                            end else begin
                                n_phase         = PH_IDLE;
                                res.frame_error = 1'b1;
                            end
                        end
                        PH_BIT_SPACE: begin
                            if (t >= BIT_SPACE_LO && t <= BIT_SPACE_HI) begin
                                n_shift = shifted;
                                if (r_bits == CNT_W'(CODE_BITS - 1)) begin
                                    // Last bit: report the frame and lock.
                                    n_phase        = PH_IDLE;
                                    n_locked       = 1'b1;
                                    res.code_valid = 1'b1;
                                    res.frame_code = code_ext[31:0];
                                    res.button     = code_ext[15:8];
                                end else begin
                                    n_bits  = r_bits + 1'b1;
                                    n_phase = PH_BIT_MARK;
                                end
                            end else begin
                                n_phase         = PH_IDLE;
                                res.frame_error = 1'b1;
                            end
                        end
                        default: begin
                            // First edge arms the decoder.
                            n_bits  = '0;
                            n_shift = '0;
                            n_phase = PH_LEAD_MARK;
                        end
                    endcase
                end
            end
            CMD_TIMEOUT: begin
                if (r_phase != PH_IDLE) begin
                    n_phase         = PH_IDLE;
                    res.frame_error = 1'b1;
                end
            end
            CMD_REARM: begin
                n_locked = 1'b0;
            end
            default: begin
            end
        endcase
    end

    // Decoder state, updated once per request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_bits   <= '0;
            r_shift  <= '0;
            r_locked <= 1'b0;
        end else if (i_advance) begin
            r_phase  <= n_phase;
            r_bits   <= n_bits;
            r_shift  <= n_shift;
            r_locked <= n_locked;
        end
    end

    assign o_res = res;

`ifndef SYNTH
    // A completed frame locks the decoder.
    a_done_locks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && res.code_valid) |=> r_locked)
        else $error("frame completed without locking");

    // Only a rearm request releases the lock.
    a_lock_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_locked && !(i_advance && i_item.cmd == CMD_REARM)) |=> r_locked)
        else $error("lock released without rearm");

    // An error always sends the decoder back to idle.
    a_error_idles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && res.frame_error) |=> (r_phase == PH_IDLE))
        else $error("error did not return to idle");

    // While locked the decoder sits idle.
    a_locked_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_locked |-> (r_phase == PH_IDLE))
        else $error("locked while decoding");
`endif

endmodule : necd_fsm

`default_nettype wire

// ----- src/necd_out_reg.sv -----
// Result register of the NEC decoder: holds one result until the sink takes it.
// Depends on necd_pkg and necd_res_if.
`timescale 1ns / 1ps
`default_nettype none

module necd_out_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire necd_pkg::t_result i_res,
    output logic                   o_free,
    necd_res_if.source             o_res
);
    import necd_pkg::*;

    logic    r_valid;
    t_result r_res;

    // Free when empty or when the held result is taken this cycle.
    assign o_free = !r_valid || o_res.ready;

    // Valid flag of the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_res.valid       = r_valid;
    assign o_res.code_valid  = r_res.code_valid;
    assign o_res.frame_code  = r_res.frame_code;
    assign o_res.button      = r_res.button;
    assign o_res.frame_error = r_res.frame_error;

endmodule : necd_out_reg

`default_nettype wire

// ----- src/nec_ir_frame_decoder_core.sv -----
// NEC infrared frame decoder: top level joining input register, state machine and result register.
// Depends on necd_pkg, necd_req_if, necd_res_if, necd_in_reg, necd_fsm and necd_out_reg.
//
// The decoder takes one request per clock cycle (edge, timeout or rearm) while the sink keeps up
// and returns exactly one result for each: the request is held in the input register, then the
// window checks, bit shift and state update happen in a single pass as the request moves into
// the result register. The result register frees in the same cycle the sink takes its content,
// so with the sink always ready the sustained rate is one request per cycle; a stalled sink
// holds both registers and then ready drops. Reset is synchronous and active low, and after it
// the decoder is idle, unlocked and waiting for the arming edge.
`timescale 1ns / 1ps
`default_nettype none

module nec_ir_frame_decoder_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    necd_req_if.sink   i_req,
    necd_res_if.source o_res
);
    import necd_pkg::*;

    logic    in_valid;
    t_req    in_item;
    logic    out_free;
    logic    advance;
    t_result fsm_res;

    // A request moves on when the result register can take its result.
    assign advance = in_valid && out_free;

    necd_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .i_advance (advance),
        .o_valid   (in_valid),
        .o_item    (in_item)
    );

    necd_fsm u_fsm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (in_item),
        .o_res     (fsm_res)
    );

    necd_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance),
        .i_res   (fsm_res),
        .o_free  (out_free),
        .o_res   (o_res)
    );

endmodule : nec_ir_frame_decoder_core

`default_nettype wire
